### sv/ncp_pkg.sv
// Shared types, constants and functions of the nearest colour palette unit.
// Depends on nothing; the controller, datapath and top level refer to it by scoped names.
`timescale 1ns / 1ps

package ncp_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int COMP_W  = 8;
  localparam int WORD_W  = 3 * COMP_W;
  localparam int DIST_W  = 18;

  // Squared normalized distance 1.0 in units of 1/65025.
  localparam logic [DIST_W-1:0] FULL_SCALE_SQ = 18'd65025;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_CLOSEST = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic load;        // capture a new item
    logic issue;       // read the next palette entry of the scan
    logic read_entry;  // read the entry that a read item names
    logic finish;      // form the result and update the palette
  } ncp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       no_merge;
    logic       all_issued;
    logic       pipe_empty;
  } ncp_stat_t;

  function automatic logic [2*COMP_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    begin
      d = (a > b) ? (a - b) : (b - a);
      sq_diff = d * d;
    end
  endfunction

  function automatic logic [DIST_W-1:0] dist2(input logic [WORD_W-1:0] w,
                                              input logic [COMP_W-1:0] r,
                                              input logic [COMP_W-1:0] g,
                                              input logic [COMP_W-1:0] b);
    begin
      dist2 = DIST_W'(sq_diff(w[WORD_W-1 -: COMP_W], r))
            + DIST_W'(sq_diff(w[2*COMP_W-1 -: COMP_W], g))
            + DIST_W'(sq_diff(w[COMP_W-1:0], b));
    end
  endfunction

endpackage

### sv/ncp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module ncp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/ncp_ctrl.sv
// Controller of the nearest colour palette unit: sequences decode, scan,
// entry read and result. Depends on ncp_pkg for the command and status types.
`timescale 1ns / 1ps

module ncp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ncp_pkg::ncp_stat_t stat,
  output ncp_pkg::ncp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((stat.kind == ncp_pkg::KIND_ADD && !stat.no_merge) ||
            stat.kind == ncp_pkg::KIND_CLOSEST) begin
          state_nxt = S_SCAN;
        end else if (stat.kind == ncp_pkg::KIND_READ) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        // Keep issuing entries until all are out, then let the pipeline drain.
        if (!stat.all_issued) begin
          cmd.issue = 1'b1;
        end else if (stat.pipe_empty) begin
          state_nxt = S_FINISH;
        end
      end
      S_READ: begin
        cmd.read_entry = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### sv/ncp_dp.sv
// Datapath of the nearest colour palette unit: item registers, palette RAM,
// distance pipeline, best-match tracking and result registers.
// Depends on ncp_pkg and ncp_ram.
`timescale 1ns / 1ps

module ncp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ncp_pkg::ncp_cmd_t            cmd,
  output ncp_pkg::ncp_stat_t           stat,
  input  logic [1:0]                   in_kind,
  input  logic [ncp_pkg::COMP_W-1:0]   in_red,
  input  logic [ncp_pkg::COMP_W-1:0]   in_green,
  input  logic [ncp_pkg::COMP_W-1:0]   in_blue,
  input  logic [ncp_pkg::DIST_W-1:0]   in_merge_limit,
  input  logic                         in_no_merge,
  input  logic [ncp_pkg::IDX_W-1:0]    in_entry_index,
  output logic                         out_valid,
  output logic [ncp_pkg::IDX_W-1:0]    out_index,
  output logic [ncp_pkg::COMP_W-1:0]   out_red,
  output logic [ncp_pkg::COMP_W-1:0]   out_green,
  output logic [ncp_pkg::COMP_W-1:0]   out_blue,
  output logic [ncp_pkg::CNT_W-1:0]    out_entry_count,
  output logic [1:0]                   out_status
);

  // Item registers.
  logic [1:0]                  kind_r;
  logic [ncp_pkg::COMP_W-1:0]  red_r, green_r, blue_r;
  logic [ncp_pkg::DIST_W-1:0]  limit_r;
  logic                        no_merge_r;
  logic [ncp_pkg::IDX_W-1:0]   sel_r;

  // Palette fill count and scan state.
  logic [ncp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ncp_pkg::CNT_W-1:0]   scan_r;
  logic                        v1_r, v2_r;
  logic [ncp_pkg::IDX_W-1:0]   tag1_r, tag2_r;
  logic [ncp_pkg::DIST_W-1:0]  dist_r;
  logic                        found_r;
  logic [ncp_pkg::DIST_W-1:0]  best_r;
  logic [ncp_pkg::IDX_W-1:0]   best_idx_r;

  // RAM ports.
  logic                        ram_we, ram_re;
  logic [ncp_pkg::IDX_W-1:0]   ram_raddr;
  logic [ncp_pkg::WORD_W-1:0]  ram_rdata;

  // Result forming.
  logic [ncp_pkg::IDX_W-1:0]   res_idx;
  logic [ncp_pkg::COMP_W-1:0]  res_r, res_g, res_b;
  logic [1:0]                  res_status;
  logic                        full;
  logic                        out_valid_r;

  assign full      = (cnt_r == ncp_pkg::CNT_W'(ncp_pkg::ENTRIES));
  assign ram_re    = cmd.issue | cmd.read_entry;
  assign ram_raddr = cmd.read_entry ? sel_r : scan_r[ncp_pkg::IDX_W-1:0];

  always_comb begin
    res_idx    = '0;
    res_r      = '0;
    res_g      = '0;
    res_b      = '0;
    res_status = ncp_pkg::ST_OK;
    cnt_nxt    = cnt_r;
    ram_we     = 1'b0;
    case (kind_r)
      ncp_pkg::KIND_ADD: begin
        if (found_r) begin
          res_idx = best_idx_r;
        end else if (full) begin
          res_status = ncp_pkg::ST_FULL;
        end else begin
          res_idx = cnt_r[ncp_pkg::IDX_W-1:0];
          ram_we  = cmd.finish;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ncp_pkg::KIND_CLOSEST: begin
        res_idx = best_idx_r;
      end
      ncp_pkg::KIND_READ: begin
        if (ncp_pkg::CNT_W'(sel_r) < cnt_r) begin
          res_idx = sel_r;
          res_r   = ram_rdata[ncp_pkg::WORD_W-1 -: ncp_pkg::COMP_W];
          res_g   = ram_rdata[2*ncp_pkg::COMP_W-1 -: ncp_pkg::COMP_W];
          res_b   = ram_rdata[ncp_pkg::COMP_W-1:0];
        end else begin
          res_status = ncp_pkg::ST_RANGE;
        end
      end
      default: begin
        res_idx = '0;
      end
    endcase
  end

  ncp_ram #(
    .WIDTH(ncp_pkg::WORD_W),
    .DEPTH(ncp_pkg::ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[ncp_pkg::IDX_W-1:0]),
    .wdata({red_r, green_r, blue_r}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= cmd.finish;
      if (cmd.finish) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= in_kind;
      red_r      <= in_red;
      green_r    <= in_green;
      blue_r     <= in_blue;
      limit_r    <= in_merge_limit;
      no_merge_r <= in_no_merge;
      sel_r      <= in_entry_index;
      scan_r     <= '0;
      found_r    <= 1'b0;
      best_r     <= ncp_pkg::FULL_SCALE_SQ;
      best_idx_r <= '0;
    end else begin
      if (cmd.issue) begin
        scan_r <= scan_r + 1'b1;
      end
      // The first entry within the limit wins for add; the first entry with
      // the strictly smallest distance wins for closest.
      if (v2_r) begin
        if (kind_r == ncp_pkg::KIND_ADD) begin
          if (!found_r && dist_r <= limit_r) begin
            found_r    <= 1'b1;
            best_idx_r <= tag2_r;
          end
        end else if (dist_r < best_r) begin
          best_r     <= dist_r;
          best_idx_r <= tag2_r;
        end
      end
    end
    tag1_r <= scan_r[ncp_pkg::IDX_W-1:0];
    tag2_r <= tag1_r;
    dist_r <= ncp_pkg::dist2(ram_rdata, red_r, green_r, blue_r);
    if (cmd.finish) begin
      out_index       <= res_idx;
      out_red         <= res_r;
      out_green       <= res_g;
      out_blue        <= res_b;
      out_entry_count <= cnt_nxt;
      out_status      <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign stat.kind       = kind_r;
  assign stat.no_merge   = no_merge_r;
  assign stat.all_issued = (scan_r >= cnt_r);
  assign stat.pipe_empty = !v1_r && !v2_r;

endmodule

### sv/nearest_colour_palette_unit.sv
// Top level of the nearest colour palette unit: joins controller and datapath.
// Depends on ncp_pkg, ncp_ctrl, ncp_dp and ncp_ram.
//
// Usage. The block keeps a palette of up to 256 RGB entries of 3 x 8 bits.
// An item is accepted at a rising edge where start is high and busy is low;
// the in_ ports carry the request: add a colour (merging into the first entry
// within in_merge_limit unless in_no_merge is set), find the closest entry
// below full scale, or read one entry.
// Each item gives exactly one result. It is shown on the out_ ports for one
// cycle while out_valid is high, and the receiver must take it then; it
// cannot stall the block.
// Sequencing. An add with merging and a closest search scan the n stored entries
// one per cycle through the palette RAM's single read port, followed by a
// two-stage distance pipeline, which drains before the result is formed.
// A read fetches one entry; an add without merging or an unused kind goes straight to the result.
// Busy falls as out_valid rises, so the next item may be accepted in the
// cycle its predecessor's result is shown. One item is in work at a time.
// Reset empties the palette by clearing the entry count; the RAM contents
// need no clearing since only entries below the count ever reach a result.
`timescale 1ns / 1ps

module nearest_colour_palette_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [ncp_pkg::COMP_W-1:0]   in_red,
  input  logic [ncp_pkg::COMP_W-1:0]   in_green,
  input  logic [ncp_pkg::COMP_W-1:0]   in_blue,
  input  logic [ncp_pkg::DIST_W-1:0]   in_merge_limit,
  input  logic                         in_no_merge,
  input  logic [ncp_pkg::IDX_W-1:0]    in_entry_index,
  output logic                         out_valid,
  output logic [ncp_pkg::IDX_W-1:0]    out_index,
  output logic [ncp_pkg::COMP_W-1:0]   out_red,
  output logic [ncp_pkg::COMP_W-1:0]   out_green,
  output logic [ncp_pkg::COMP_W-1:0]   out_blue,
  output logic [ncp_pkg::CNT_W-1:0]    out_entry_count,
  output logic [1:0]                   out_status
);

  ncp_pkg::ncp_cmd_t  cmd;
  ncp_pkg::ncp_stat_t stat;

  // The controller sequences the item; the datapath holds all storage.
  ncp_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  ncp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_merge_limit (in_merge_limit),
    .in_no_merge    (in_no_merge),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_index      (out_index),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_entry_count(out_entry_count),
    .out_status     (out_status)
  );

endmodule
